// ----- hw/rtl/lge_pkg.sv -----
// Shared types and constants for the life generation engine.
// No dependencies; used by every module of the block except lge_ram.
package lge_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;
   localparam int CFG_W        = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int DIM_RESET    = 64;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] row;
      logic [5:0] col;
      logic       alive;
   } req_type;

   typedef struct packed {
      logic cell_state;
      logic out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_CELL_WRITE,
      OP_CELL_READ,
      OP_STEP_PRIME,
      OP_STEP_ROW,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      logic rsp_free;
      logic clear_last;
      logic step_last;
   } dp_status_type;

endpackage

// ----- hw/rtl/life_generation_engine_top.sv -----
// Life generation engine (B3/S23), one grid row per RAM word.
// Cell write and cell read: accept, RAM access, result; unknown command: accept, result.
// Generation step: accept, prime, one row per cycle through the RAM port, then result.
// One item at a time; the next is taken the cycle after its result is loaded.
// Synchronous reset clears control state, then a clearing pass writes every row
// to empty the grid while the request side stalls; csr writes are taken throughout.
module life_generation_engine_top #(
   parameter int MAX_ROWS = lge_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = lge_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lge_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lge_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [lge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lge_pkg::CFG_W-1:0]     csr_wdata
);

   lge_pkg::dp_op_type     op;
   lge_pkg::dp_status_type status;

   lge_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_stall(req_stall),
      .status   (status),
      .op       (op)
   );

   lge_datapath #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .status   (status),
      .req_data (req_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ----- hw/rtl/lge_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lge_ctrl.sv -----
// Sequencer for the life generation engine: clear pass, cell access, generation sweep.
// Depends on lge_pkg; drives lge_datapath through an op code.
module lge_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lge_pkg::req_type      req_data,
   output logic                  req_stall,
   input  lge_pkg::dp_status_type status,
   output lge_pkg::dp_op_type    op
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WR,
      S_RD,
      S_PRIME,
      S_ROW,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      op       = lge_pkg::OP_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            op = lge_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               op = lge_pkg::OP_ACCEPT;
               unique case (req_data.cmd)
                  lge_pkg::CMD_WRITE: state_in = S_WR;
                  lge_pkg::CMD_READ:  state_in = S_RD;
                  lge_pkg::CMD_STEP:  state_in = S_PRIME;
                  default:            state_in = S_OUT;
               endcase
            end
         end
         S_WR: begin
            op       = lge_pkg::OP_CELL_WRITE;
            state_in = S_OUT;
         end
         S_RD: begin
            op       = lge_pkg::OP_CELL_READ;
            state_in = S_OUT;
         end
         S_PRIME: begin
            op       = lge_pkg::OP_STEP_PRIME;
            state_in = S_ROW;
         end
         S_ROW: begin
            op = lge_pkg::OP_STEP_ROW;
            if (status.step_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               op       = lge_pkg::OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ----- hw/rtl/lge_datapath.sv -----
// Datapath: dimension registers, row RAM, three-row window, B3/S23 row update,
// result register. Depends on lge_pkg and lge_ram.
module lge_datapath #(
   parameter int MAX_ROWS = lge_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = lge_pkg::MAX_COLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lge_pkg::dp_op_type               op,
   output lge_pkg::dp_status_type           status,
   input  lge_pkg::req_type                 req_data,
   input  logic                             csr_wr_en,
   input  logic [lge_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lge_pkg::CFG_W-1:0]        csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lge_pkg::rsp_type                 rsp_data
);

   localparam int AW   = $clog2(MAX_ROWS);
   localparam int CW   = $clog2(MAX_COLS);
   localparam int DRW  = $clog2(MAX_ROWS + 1);
   localparam int DCW  = $clog2(MAX_COLS + 1);
   localparam int DW0  = (DRW > lge_pkg::CFG_W) ? DRW : lge_pkg::CFG_W;
   localparam int DW   = (DCW > DW0) ? DCW : DW0;

   logic [lge_pkg::CFG_W-1:0] rows_ff, cols_ff;
   logic [DW-1:0]             nr, nc;
   logic [AW-1:0]             ctr_ff, ctr_in;
   logic [AW-1:0]             lat_row_ff;
   logic [CW-1:0]             lat_col_ff;
   logic                      lat_alive_ff, lat_oor_ff;
   logic                      res_cell_ff, res_oor_ff;
   logic [MAX_COLS-1:0]       above_ff, mid_ff;
   logic [MAX_COLS-1:0]       col_mask, new_row, merged_row;
   logic                      req_oor, cell_cmd;
   logic                      rsp_valid_ff;
   lge_pkg::rsp_type          rsp_data_ff;

   logic                ram_wr_en, ram_rd_en;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [MAX_COLS-1:0] ram_wr_data, ram_rd_data;

   function automatic logic [DW-1:0] clamp_dim(input logic [lge_pkg::CFG_W-1:0] v,
                                               input int maxv);
      logic [DW-1:0] ve;
      ve = DW'(v);
      if (ve < DW'(3)) return DW'(3);
      if (ve > DW'(maxv)) return DW'(maxv);
      return ve;
   endfunction

   assign nr = clamp_dim(rows_ff, MAX_ROWS);
   assign nc = clamp_dim(cols_ff, MAX_COLS);

   assign req_oor  = (DW'(req_data.row) >= nr) || (DW'(req_data.col) >= nc);
   assign cell_cmd = (req_data.cmd == lge_pkg::CMD_WRITE) ||
                     (req_data.cmd == lge_pkg::CMD_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= lge_pkg::CFG_W'(lge_pkg::DIM_RESET);
         cols_ff <= lge_pkg::CFG_W'(lge_pkg::DIM_RESET);
      end else if (csr_wr_en) begin
         if (csr_index == lge_pkg::CSR_ROWS) rows_ff <= csr_wdata;
         if (csr_index == lge_pkg::CSR_COLS) cols_ff <= csr_wdata;
      end
   end

   // interior columns only
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = (c >= 1) && (DW'(c + 1) < nc);
      end
   end

   always_comb begin
      logic [3:0] n;
      new_row = mid_ff;
      for (int c = 1; c < MAX_COLS - 1; c++) begin
         n = 4'(above_ff[c-1]) + 4'(above_ff[c]) + 4'(above_ff[c+1]) +
             4'(mid_ff[c-1]) + 4'(mid_ff[c+1]) +
             4'(ram_rd_data[c-1]) + 4'(ram_rd_data[c]) + 4'(ram_rd_data[c+1]);
         if (col_mask[c]) begin
            new_row[c] = (n == 4'd3) || ((n == 4'd2) && mid_ff[c]);
         end
      end
   end

   always_comb begin
      merged_row             = ram_rd_data;
      merged_row[lat_col_ff] = lat_alive_ff;
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = ctr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ctr_ff;
      ctr_in      = ctr_ff;
      case (op)
         lge_pkg::OP_CLEAR: begin
            ram_wr_en = 1'b1;
            ctr_in    = ctr_ff + AW'(1);
         end
         lge_pkg::OP_ACCEPT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = (req_data.cmd == lge_pkg::CMD_STEP) ? '0 : AW'(req_data.row);
            ctr_in      = AW'(1);
         end
         lge_pkg::OP_CELL_WRITE: begin
            ram_wr_en   = !lat_oor_ff;
            ram_wr_addr = lat_row_ff;
            ram_wr_data = merged_row;
         end
         lge_pkg::OP_STEP_PRIME: begin
            ram_rd_en = 1'b1;
         end
         lge_pkg::OP_STEP_ROW: begin
            ram_wr_en   = (ctr_ff != AW'(1));
            ram_wr_addr = ctr_ff - AW'(1);
            ram_wr_data = new_row;
            ram_rd_en   = 1'b1;
            ram_rd_addr = ctr_ff + AW'(1);
            ctr_in      = ctr_ff + AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else begin
         ctr_ff <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         lge_pkg::OP_ACCEPT: begin
            lat_row_ff   <= AW'(req_data.row);
            lat_col_ff   <= CW'(req_data.col);
            lat_alive_ff <= req_data.alive;
            lat_oor_ff   <= req_oor;
            res_cell_ff  <= 1'b0;
            res_oor_ff   <= req_oor && cell_cmd;
         end
         lge_pkg::OP_CELL_READ: begin
            res_cell_ff <= !lat_oor_ff && ram_rd_data[lat_col_ff];
         end
         lge_pkg::OP_STEP_PRIME: begin
            mid_ff <= ram_rd_data;
         end
         lge_pkg::OP_STEP_ROW: begin
            above_ff <= mid_ff;
            mid_ff   <= ram_rd_data;
         end
         default: ;
      endcase
   end

   // result register parts the sequencer from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (op == lge_pkg::OP_RESPOND) || (rsp_valid_ff && rsp_stall);
      end
      if (op == lge_pkg::OP_RESPOND) begin
         rsp_data_ff.cell_state   <= res_cell_ff;
         rsp_data_ff.out_of_range <= res_oor_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign status.clear_last = (ctr_ff == AW'(MAX_ROWS - 1));
   assign status.step_last  = (DW'(ctr_ff) == nr - DW'(1));

   lge_ram #(
      .WIDTH(MAX_COLS),
      .DEPTH(MAX_ROWS)
   ) u_grid (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

// ----- hw/rtl/lge_checker.sv -----
// Port-level checks for the life generation engine, bound to the top level.
// Depends on lge_pkg and life_generation_engine_top.
module lge_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lge_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous transfer in progress");

   a_oor_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.cell_state && rsp_data.out_of_range))
      else $error("out-of-range result carries a cell value");

   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("requests accepted during clearing pass");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented straight after reset");

endmodule

bind life_generation_engine_top lge_checker u_lge_checker (.*);
